/* hdl/pbd_pkg.sv */
`timescale 1ns / 1ps

package pbd_pkg;

  localparam int POS_W     = 32;
  localparam int DIFF_W    = POS_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int ROOT_W    = DIFF_W;
  localparam int MASS_W    = 24;
  localparam int WSUM_W    = MASS_W + 1;
  localparam int REST_W    = 31;
  localparam int STIFF_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int NRM_QW    = 31;
  localparam int RAT_QW    = 17;
  localparam int MAG_W     = 34;

  localparam logic [STIFF_W-1:0] STIFF_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMPRESS = 2'd0,
    REG_STRETCH  = 2'd1
  } cfg_reg_t;

endpackage

/* hdl/pbd_delay.sv */
`timescale 1ns / 1ps

module pbd_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

/* hdl/pbd_sqrt.sv */
`timescale 1ns / 1ps

module pbd_sqrt (
  input  logic                          clk,
  input  logic [2*pbd_pkg::ROOT_W-1:0]  rad,
  output logic [pbd_pkg::ROOT_W-1:0]    root
);

  import pbd_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]    rm [ROOT_W+1];
  logic [ROOT_W-1:0]   rt [ROOT_W+1];
  logic [2*ROOT_W-1:0] rd [ROOT_W+1];

  assign rm[0] = '0;
  assign rt[0] = '0;
  assign rd[0] = rad;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;
    assign cur   = {rm[s], rd[s][2*ROOT_W-1 -: 2]};
    assign trial = {2'b00, rt[s], 2'b01};
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      rm[s+1] <= ge ? REM_W'(cur - trial) : REM_W'(cur);
      rt[s+1] <= {rt[s][ROOT_W-2:0], ge};
      rd[s+1] <= {rd[s][2*ROOT_W-3:0], 2'b00};
    end
  end

  assign root = rt[ROOT_W];

endmodule

/* hdl/pbd_div.sv */
`timescale 1ns / 1ps

module pbd_div #(
  parameter int DW = 33,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic [DW-1:0] num_hi,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] lo  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [DW-1:0] dn  [QW+1];

  assign rem[0] = num_hi;
  assign lo[0]  = num_lo;
  assign q[0]   = '0;
  assign dn[0]  = den;

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW:0] cur;
    logic        ge;
    assign cur = {rem[s], lo[s][QW-1]};
    assign ge  = (cur >= {1'b0, dn[s]});
    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? DW'(cur - {1'b0, dn[s]}) : cur[DW-1:0];
      lo[s+1]  <= {lo[s][QW-2:0], 1'b0};
      q[s+1]   <= {q[s][QW-2:0], ge};
      dn[s+1]  <= dn[s];
    end
  end

  assign quo = q[QW];

endmodule

/* hdl/pbd_distance_constraint_core.sv */
`timescale 1ns / 1ps
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+-------------------------
// config    | cfg_we, cfg_index, cfg_data                    | written when cfg_we high
// item in   | a_*, b_*, inv_mass_a/b, rest_length            | start high, busy low
// result    | new_a_*, new_b_*, applied                      | done high for one cycle
//
// One item per cycle; busy never rises. 73 register stages: 3 front stages, the
// 33-stage square root, one setup stage, the 31-stage normalize divider, 4 scaling
// stages and the output register. done rises in the same cycle as the results.
// rst sets both stiffness registers to STIFF_ONE and clears the valid chain
// and done. The output has no back-pressure; results are shown once.

module pbd_distance_constraint_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbd_pkg::STIFF_W-1:0]       cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [pbd_pkg::POS_W-1:0]  a_x,
  input  logic signed [pbd_pkg::POS_W-1:0]  a_y,
  input  logic signed [pbd_pkg::POS_W-1:0]  a_z,
  input  logic signed [pbd_pkg::POS_W-1:0]  b_x,
  input  logic signed [pbd_pkg::POS_W-1:0]  b_y,
  input  logic signed [pbd_pkg::POS_W-1:0]  b_z,
  input  logic [pbd_pkg::MASS_W-1:0]        inv_mass_a,
  input  logic [pbd_pkg::MASS_W-1:0]        inv_mass_b,
  input  logic [pbd_pkg::REST_W-1:0]        rest_length,
  output logic                              done,
  output logic signed [pbd_pkg::POS_W-1:0]  new_a_x,
  output logic signed [pbd_pkg::POS_W-1:0]  new_a_y,
  output logic signed [pbd_pkg::POS_W-1:0]  new_a_z,
  output logic signed [pbd_pkg::POS_W-1:0]  new_b_x,
  output logic signed [pbd_pkg::POS_W-1:0]  new_b_y,
  output logic signed [pbd_pkg::POS_W-1:0]  new_b_z,
  output logic                              applied
);

  import pbd_pkg::*;

  localparam int T_SQ = 3 + ROOT_W;
  localparam int T_X  = T_SQ + 1;
  localparam int T_N  = T_X + NRM_QW;
  localparam int T_R  = T_X + RAT_QW;
  localparam int T_C  = T_N + 2;
  localparam int T_K  = T_N + 3;
  localparam int T_M  = T_N + 4;
  localparam int SUM_W = POS_W + 4;
  localparam int PL_W  = NRM_QW + 17;
  localparam int PH_W  = NRM_QW + 16;
  localparam int KP_W  = MAG_W + STIFF_W;
  localparam int NN_W  = 2 * NRM_QW + 2;
  localparam int RN_W  = WSUM_W + RAT_QW;

  logic [STIFF_W-1:0] compress_stiffness;
  logic [STIFF_W-1:0] stretch_stiffness;
  logic [T_M:1]       vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      compress_stiffness <= STIFF_ONE;
      stretch_stiffness  <= STIFF_ONE;
      vld                <= '0;
      done               <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COMPRESS: compress_stiffness <= cfg_data;
          REG_STRETCH:  stretch_stiffness  <= cfg_data;
          default: ;
        endcase
      end
      vld  <= {vld[T_M-1:1], start & ~busy};
      done <= vld[T_M];
    end
  end

  // stage 1
  logic signed [POS_W-1:0]  a1 [3];
  logic signed [POS_W-1:0]  b1 [3];
  logic signed [DIFF_W-1:0] v1 [3];
  logic [MASS_W-1:0]        wa1, wb1;
  logic [REST_W-1:0]        rest1;
  logic                     zw1;

  always_ff @(posedge clk) begin
    a1[0] <= a_x;  a1[1] <= a_y;  a1[2] <= a_z;
    b1[0] <= b_x;  b1[1] <= b_y;  b1[2] <= b_z;
    v1[0] <= DIFF_W'(b_x) - DIFF_W'(a_x);
    v1[1] <= DIFF_W'(b_y) - DIFF_W'(a_y);
    v1[2] <= DIFF_W'(b_z) - DIFF_W'(a_z);
    wa1   <= inv_mass_a;
    wb1   <= inv_mass_b;
    rest1 <= rest_length;
    zw1   <= (inv_mass_a == '0) && (inv_mass_b == '0);
  end

  // stage 2: squares and magnitudes
  logic [SQ_W-1:0]     sq2 [3];
  logic [DIFF_W-1:0]   vm2 [3];
  logic [2:0]          vneg2;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic signed [SQ_W-1:0] vx;
    assign vx = SQ_W'(v1[i]);
    always_ff @(posedge clk) begin
      sq2[i]   <= SQ_W'(vx * vx);
      vm2[i]   <= v1[i][DIFF_W-1] ? DIFF_W'(-v1[i]) : DIFF_W'(v1[i]);
      vneg2[i] <= v1[i][DIFF_W-1];
    end
  end

  // stage 3: sum of squares
  logic [SQ_W-1:0] sum3;

  always_ff @(posedge clk) begin
    sum3 <= sq2[0] + sq2[1] + sq2[2];
  end

  logic [ROOT_W-1:0] root_d;

  pbd_sqrt u_sqrt (
    .clk  (clk),
    .rad  (sum3),
    .root (root_d)
  );

  logic [2*MASS_W+REST_W-1:0] wr_sq;
  logic [3*DIFF_W+2:0]        vm_sq;
  logic [MASS_W-1:0]          wa_sq, wb_sq;
  logic [REST_W-1:0]          rest_sq;
  logic [DIFF_W-1:0]          vm_x [3];
  logic [2:0]                 vneg_x;

  pbd_delay #(.WIDTH(2*MASS_W+REST_W), .DEPTH(T_SQ-1)) u_dly_w (
    .clk (clk),
    .din ({wa1, wb1, rest1}),
    .dout(wr_sq)
  );

  pbd_delay #(.WIDTH(3*DIFF_W+3), .DEPTH(T_SQ-2)) u_dly_v (
    .clk (clk),
    .din ({vm2[0], vm2[1], vm2[2], vneg2}),
    .dout(vm_sq)
  );

  assign {wa_sq, wb_sq, rest_sq}               = wr_sq;
  assign {vm_x[0], vm_x[1], vm_x[2], vneg_x}   = vm_sq;

  // stage X: error, stiffness, divider operands
  logic                lt_x;
  logic [ROOT_W-1:0]   rest_ext;
  logic [STIFF_W-1:0]  k_sel;
  logic [WSUM_W-1:0]   ws_x;
  logic [RN_W-1:0]     ran_x, rbn_x;

  logic [ROOT_W-1:0]   em37;
  logic [STIFF_W-1:0]  k37;
  logic [2:0]          neg37;
  logic                zd37;
  logic [ROOT_W-1:0]   nhi37 [3];
  logic [NRM_QW-1:0]   nlo37 [3];
  logic [ROOT_W-1:0]   d37;
  logic [WSUM_W-1:0]   ahi37, bhi37, ws37;
  logic [RAT_QW-1:0]   alo37, blo37;

  assign rest_ext = ROOT_W'(rest_sq);
  assign lt_x     = root_d < rest_ext;
  assign k_sel    = lt_x ? compress_stiffness : stretch_stiffness;
  assign ws_x     = WSUM_W'(wa_sq) + WSUM_W'(wb_sq);
  assign ran_x    = {wa_sq, 16'b0} + RN_W'(ws_x >> 1);
  assign rbn_x    = {wb_sq, 16'b0} + RN_W'(ws_x >> 1);

  for (genvar i = 0; i < 3; i++) begin : g_num
    logic [NN_W-1:0] nn;
    assign nn = {vm_x[i], 30'b0} + NN_W'(root_d >> 1);
    always_ff @(posedge clk) begin
      nhi37[i] <= nn[NN_W-1:NRM_QW];
      nlo37[i] <= nn[NRM_QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    em37  <= lt_x ? rest_ext - root_d : root_d - rest_ext;
    k37   <= (k_sel > STIFF_ONE) ? STIFF_ONE : k_sel;
    neg37 <= vneg_x ^ {3{lt_x}};
    zd37  <= (root_d == '0);
    d37   <= root_d;
    ws37  <= ws_x;
    ahi37 <= ran_x[RN_W-1:RAT_QW];
    alo37 <= ran_x[RAT_QW-1:0];
    bhi37 <= rbn_x[RN_W-1:RAT_QW];
    blo37 <= rbn_x[RAT_QW-1:0];
  end

  logic [NRM_QW-1:0] nm [3];

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    pbd_div #(.DW(ROOT_W), .QW(NRM_QW)) u_div (
      .clk   (clk),
      .num_hi(nhi37[i]),
      .num_lo(nlo37[i]),
      .den   (d37),
      .quo   (nm[i])
    );
  end

  logic [RAT_QW-1:0] ra_q, rb_q, ra71, rb71;

  pbd_div #(.DW(WSUM_W), .QW(RAT_QW)) u_div_ra (
    .clk   (clk),
    .num_hi(ahi37),
    .num_lo(alo37),
    .den   (ws37),
    .quo   (ra_q)
  );

  pbd_div #(.DW(WSUM_W), .QW(RAT_QW)) u_div_rb (
    .clk   (clk),
    .num_hi(bhi37),
    .num_lo(blo37),
    .den   (ws37),
    .quo   (rb_q)
  );

  pbd_delay #(.WIDTH(2*RAT_QW), .DEPTH(T_K-T_R)) u_dly_r (
    .clk (clk),
    .din ({ra_q, rb_q}),
    .dout({ra71, rb71})
  );

  logic [ROOT_W-1:0]  em68;
  logic [STIFF_W-1:0] k70;
  logic [2:0]         neg72;
  logic               zd72;

  pbd_delay #(.WIDTH(ROOT_W), .DEPTH(T_N-T_X)) u_dly_e (
    .clk (clk),
    .din (em37),
    .dout(em68)
  );

  pbd_delay #(.WIDTH(STIFF_W), .DEPTH(T_C-T_X)) u_dly_k (
    .clk (clk),
    .din (k37),
    .dout(k70)
  );

  pbd_delay #(.WIDTH(4), .DEPTH(T_M-T_X)) u_dly_n (
    .clk (clk),
    .din ({neg37, zd37}),
    .dout({neg72, zd72})
  );

  logic [6*POS_W:0]        ab72;
  logic signed [POS_W-1:0] a72 [3];
  logic signed [POS_W-1:0] b72 [3];
  logic                    zw72;

  pbd_delay #(.WIDTH(6*POS_W+1), .DEPTH(T_M-1)) u_dly_ab (
    .clk (clk),
    .din ({a1[0], a1[1], a1[2], b1[0], b1[1], b1[2], zw1}),
    .dout(ab72)
  );

  assign {a72[0], a72[1], a72[2], b72[0], b72[1], b72[2], zw72} = ab72;

  // scaling chain
  logic [PL_W-1:0]   pl [3];
  logic [PH_W-1:0]   ph [3];
  logic [MAG_W-1:0]  cm [3];
  logic [MAG_W-1:0]  km [3];
  logic [MAG_W-1:0]  ma [3];
  logic [MAG_W-1:0]  mb [3];
  logic signed [POS_W-1:0] res_a [3];
  logic signed [POS_W-1:0] res_b [3];

  for (genvar i = 0; i < 3; i++) begin : g_scale
    logic [63:0]             csum;
    logic [KP_W-1:0]         kp, ap, bp;
    logic signed [SUM_W-1:0] sa, sb, mas, mbs;
    logic signed [POS_W-1:0] fa, fb;

    assign csum = 64'(pl[i]) + {ph[i], 17'b0} + 64'(1 << 29);
    assign kp   = KP_W'(cm[i]) * KP_W'(k70) + KP_W'(1 << 15);
    assign ap   = KP_W'(km[i]) * KP_W'(ra71) + KP_W'(1 << 15);
    assign bp   = KP_W'(km[i]) * KP_W'(rb71) + KP_W'(1 << 15);
    assign mas  = neg72[i] ? -SUM_W'(ma[i]) : SUM_W'(ma[i]);
    assign mbs  = neg72[i] ? -SUM_W'(mb[i]) : SUM_W'(mb[i]);
    assign sa   = SUM_W'(a72[i]) + mas;
    assign sb   = SUM_W'(b72[i]) - mbs;

    always_comb begin
      if (sa > SUM_W'(32'sh7fffffff)) begin
        fa = 32'sh7fffffff;
      end else if (sa < -SUM_W'(33'sh080000000)) begin
        fa = 32'sh80000000;
      end else begin
        fa = sa[POS_W-1:0];
      end
      if (sb > SUM_W'(32'sh7fffffff)) begin
        fb = 32'sh7fffffff;
      end else if (sb < -SUM_W'(33'sh080000000)) begin
        fb = 32'sh80000000;
      end else begin
        fb = sb[POS_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      pl[i] <= PL_W'(nm[i]) * PL_W'(em68[16:0]);
      ph[i] <= PH_W'(nm[i]) * PH_W'(em68[ROOT_W-1:17]);
      cm[i] <= csum[63:30];
      km[i] <= kp[KP_W-2:16];
      ma[i] <= ap[KP_W-2:16];
      mb[i] <= bp[KP_W-2:16];
      if (zw72 || zd72) begin
        res_a[i] <= a72[i];
        res_b[i] <= b72[i];
      end else begin
        res_a[i] <= fa;
        res_b[i] <= fb;
      end
    end
  end

  always_ff @(posedge clk) begin
    applied <= ~zw72;
  end

  assign new_a_x = res_a[0];
  assign new_a_y = res_a[1];
  assign new_a_z = res_a[2];
  assign new_b_x = res_b[0];
  assign new_b_y = res_b[1];
  assign new_b_z = res_b[2];

endmodule

/* test/pbd_distance_constraint_core_tb.sv */
`timescale 1ns / 1ps

module pbd_distance_constraint_core_tb;
  import pbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 90;
  localparam int RAND_ITEMS = 1540;

  typedef struct packed {
    logic [2:0][POS_W-1:0] a;
    logic [2:0][POS_W-1:0] b;
    logic [MASS_W-1:0] wa;
    logic [MASS_W-1:0] wb;
    logic [REST_W-1:0] rest;
  } cons_item_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] na;
    logic [2:0][POS_W-1:0] nb;
    logic applied;
  } cons_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STIFF_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  cons_item_t cur = '0;
  logic done;
  logic signed [POS_W-1:0] new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z;
  logic applied;

  bit [STIFF_W-1:0] compress_k = STIFF_ONE;
  bit [STIFF_W-1:0] stretch_k = STIFF_ONE;
  cons_result_t pending_moves[$];
  int gap_pct = 0;
  int mismatches = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pbd_distance_constraint_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .a_x(cur.a[0]), .a_y(cur.a[1]), .a_z(cur.a[2]),
    .b_x(cur.b[0]), .b_y(cur.b[1]), .b_z(cur.b[2]),
    .inv_mass_a(cur.wa), .inv_mass_b(cur.wb), .rest_length(cur.rest),
    .done(done),
    .new_a_x(new_a_x), .new_a_y(new_a_y), .new_a_z(new_a_z),
    .new_b_x(new_b_x), .new_b_y(new_b_y), .new_b_z(new_b_z),
    .applied(applied)
  );

  function automatic logic [POS_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic cons_result_t solve_constraint(cons_item_t it);
    cons_result_t r;
    longint av, bv, vv, sa, sb;
    bit [127:0] sq, t, root, vm, em, nm, cm, km, ma, mb, ra, rb, wsum, k;
    bit neg, short;
    r.na = it.a;
    r.nb = it.b;
    wsum = it.wa + it.wb;
    r.applied = (wsum != 0);
    if (wsum == 0) return r;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      av = $signed(it.a[i]);
      bv = $signed(it.b[i]);
      vv = bv - av;
      vm = (vv < 0) ? -vv : vv;
      sq += vm * vm;
    end
    root = 0;
    for (int bt = 33; bt >= 0; bt--) begin
      t = root | (128'd1 << bt);
      if (t * t <= sq) root = t;
    end
    if (root == 0) return r;
    short = root < it.rest;
    em = short ? it.rest - root : root - it.rest;
    k = short ? compress_k : stretch_k;
    if (k > STIFF_ONE) k = STIFF_ONE;
    ra = ((it.wa << 16) + (wsum >> 1)) / wsum;
    rb = ((it.wb << 16) + (wsum >> 1)) / wsum;
    for (int i = 0; i < 3; i++) begin
      av = $signed(it.a[i]);
      bv = $signed(it.b[i]);
      vv = bv - av;
      vm = (vv < 0) ? -vv : vv;
      neg = (vv < 0) != short;
      nm = ((vm << 30) + (root >> 1)) / root;
      cm = (nm * em + (128'd1 << 29)) >> 30;
      km = (cm * k + 128'd32768) >> 16;
      ma = (km * ra + 128'd32768) >> 16;
      mb = (km * rb + 128'd32768) >> 16;
      sa = neg ? -longint'(ma[63:0]) : longint'(ma[63:0]);
      sb = neg ? -longint'(mb[63:0]) : longint'(mb[63:0]);
      r.na[i] = clamp32(av + sa);
      r.nb[i] = clamp32(bv - sb);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cons_result_t got, want;
    if (!rst && done) begin
      got.na = {new_a_z, new_a_y, new_a_x};
      got.nb = {new_b_z, new_b_y, new_b_x};
      got.applied = applied;
      if (pending_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_moves.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.na[i] !== want.na[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("new_a[%0d] exp %h got %h", i, want.na[i], got.na[i]);
          end
          if (got.nb[i] !== want.nb[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("new_b[%0d] exp %h got %h", i, want.nb[i], got.nb[i]);
          end
        end
        if (got.applied !== want.applied) begin
          mismatches++;
          if (mismatches <= 10)
            $display("applied exp %b got %b", want.applied, got.applied);
        end
      end
    end
  end

  task automatic send_item(cons_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    cur <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_moves.push_back(solve_constraint(it));
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STIFF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COMPRESS) compress_k = val;
    else if (idx == REG_STRETCH) stretch_k = val;
  endtask

  function automatic cons_item_t make_item(logic signed [31:0] ax, ay, az, bx, by, bz,
                                           logic [23:0] wa, wb, logic [30:0] rest);
    cons_item_t it;
    it.a = {az, ay, ax};
    it.b = {bz, by, bx};
    it.wa = wa;
    it.wb = wb;
    it.rest = rest;
    return it;
  endfunction

  function automatic cons_item_t random_item();
    cons_item_t it;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      it.a[i] = $urandom;
      it.b[i] = $urandom;
    end
    it.wa = MASS_W'($urandom);
    it.wb = MASS_W'($urandom);
    it.rest = REST_W'($urandom);
    if (mode < 6) begin
      for (int i = 0; i < 3; i++) begin
        it.a[i] = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        it.b[i] = it.a[i] + $signed($urandom_range(0, 2 ** 19)) - 2 ** 18;
      end
      it.rest = REST_W'($urandom_range(0, 2 ** 19));
      if ($urandom_range(4) == 0) it.wa = '0;
      else if ($urandom_range(4) == 0) it.wb = '0;
      else if ($urandom_range(1)) begin
        it.wa = MASS_W'($urandom_range(1, 2 ** 17));
        it.wb = MASS_W'($urandom_range(1, 2 ** 17));
      end
    end else if (mode == 8) begin
      if ($urandom_range(1)) begin
        it.wa = '0;
        it.wb = '0;
      end else it.b = it.a;
    end else if (mode == 9) begin
      for (int i = 0; i < 3; i++)
        it.a[i] = $urandom_range(1) ? 32'h7FFF_0000 + $urandom_range(65535)
                                     : 32'h8000_0000 + $urandom_range(65535);
      it.rest = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
    end
    return it;
  endfunction

  task automatic test_directed_defaults();
    send_item(make_item(0, 0, 0, 32'sh10000, 0, 0, 24'h10000, 24'h10000, 31'h8000));
    send_item(make_item(0, 0, 0, 32'sh8000, 0, 0, 24'h10000, 24'h10000, 31'h10000));
    send_item(make_item(1, 2, 3, 4, 5, 6, '0, '0, 31'h100));
    send_item(make_item(5, -5, 7, 5, -5, 7, 24'h1, 24'h2, 31'h1000));
    send_item(make_item(0, 0, 0, 32'sh30000, 32'sh40000, 0, '0, 24'h10000, '0));
    send_item(make_item(0, 0, 0, 32'sh30000, 32'sh40000, 0, 24'h10000, '0, 31'h7FFF_FFFF));
    send_item(make_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        24'hFFFFFF, 24'hFFFFFF, '0));
    send_item(make_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        24'hFFFFFF, 24'h1, 31'h7FFF_FFFF));
    send_item(make_item(32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFF0, 0, 0,
                        24'h1, 24'hFFFFFF, 31'h7FFF_FFFF));
    send_item(make_item(-1, -1, -1, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 31'h1));
    send_item(make_item(0, 0, 0, 1, 0, 0, 24'h1, 24'h1, '0));
    go_idle();
  endtask

  task automatic test_stiffness_extremes();
    write_reg(REG_COMPRESS, '0);
    write_reg(REG_STRETCH, STIFF_ONE);
    send_item(make_item(0, 0, 0, 32'sh8000, 0, 0, 24'h10000, 24'h10000, 31'h10000));
    send_item(make_item(0, 0, 0, 32'sh20000, 0, 0, 24'h10000, 24'h10000, 31'h10000));
    go_idle();
    write_reg(REG_COMPRESS, 17'h1FFFF);
    write_reg(REG_STRETCH, 17'd0);
    write_reg(REG_SPARE_A, 17'd123);
    write_reg(REG_SPARE_B, 17'h1FFFF);
    send_item(make_item(0, 0, 0, 32'sh8000, 0, 0, 24'h10000, 24'h10000, 31'h10000));
    send_item(make_item(0, 0, 0, 32'sh20000, 0, 0, 24'h10000, 24'h10000, 31'h10000));
    go_idle();
    write_reg(REG_STRETCH, 17'h10001);
    send_item(make_item(0, 0, 0, 32'sh20000, 0, 0, 24'h10000, 24'h10000, 31'h10000));
    go_idle();
  endtask

  task automatic test_random_stream(int pct, int count);
    write_reg(REG_COMPRESS, STIFF_W'($urandom_range(0, 17'h1FFFF)));
    write_reg(REG_STRETCH, STIFF_W'($urandom_range(0, 17'h1FFFF)));
    gap_pct = pct;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 50) begin
        gap_pct = 0;
        for (int j = 0; j < 20; j++) send_item(random_item());
        gap_pct = pct;
      end
      send_item(random_item());
    end
    go_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_stiffness_extremes();
    test_random_stream(30, RAND_ITEMS / 3);
    test_random_stream(72, RAND_ITEMS / 3);
    test_random_stream(0, RAND_ITEMS / 3);
    if (pending_moves.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("pbd_distance_constraint_core_tb OK");
    end else begin
      $display("pbd_distance_constraint_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("pbd_distance_constraint_core_tb NOT OK");
    $finish;
  end

endmodule

/* pbd_distance_constraint_core.f */
hdl/pbd_pkg.sv
hdl/pbd_delay.sv
hdl/pbd_sqrt.sv
hdl/pbd_div.sv
hdl/pbd_distance_constraint_core.sv
test/pbd_distance_constraint_core_tb.sv
